// File: hdl/slfp_pkg.sv
// slfp_pkg: shared types, constants and helpers of the sync/length frame parser
// no dependencies; imported by every module of the block

package slfp_pkg;

	localparam int MAX_PAYLOAD = 64;

	localparam int BYTE_W  = 8;
	localparam int PHASE_W = 2;
	localparam int IDX_W   = 6;
	localparam int CNT_W   = $clog2(MAX_PAYLOAD + 1);
	localparam int CMP_W   = ((CNT_W > BYTE_W) ? CNT_W : BYTE_W) + 1;

	// apb register map
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 3;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_SYNC_VALUE = 1'b0;

	// phase codes as they appear on parse_phase
	localparam logic [PHASE_W-1:0] CODE_SYNC = 2'd0;
	localparam logic [PHASE_W-1:0] CODE_CMD  = 2'd1;
	localparam logic [PHASE_W-1:0] CODE_LEN  = 2'd2;
	localparam logic [PHASE_W-1:0] CODE_DATA = 2'd3;

	typedef enum logic [3:0] {
		PH_SYNC = 4'b0001,
		PH_CMD  = 4'b0010,
		PH_LEN  = 4'b0100,
		PH_DATA = 4'b1000
	} phase_t;

	typedef struct packed {
		phase_t              phase;
		logic [BYTE_W-1:0]   command;
		logic [BYTE_W-1:0]   length;
		logic [CNT_W-1:0]    count;
	} state_t;

	typedef struct packed {
		logic [PHASE_W-1:0]  parse_phase;
		logic                data_valid;
		logic [IDX_W-1:0]    data_index;
		logic [BYTE_W-1:0]   data_byte;
		logic [BYTE_W-1:0]   frame_command;
		logic [BYTE_W-1:0]   frame_length;
		logic                frame_done;
	} result_t;

	function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
		logic [PHASE_W-1:0] code;
		case (ph)
			PH_SYNC: code = CODE_SYNC;
			PH_CMD:  code = CODE_CMD;
			PH_LEN:  code = CODE_LEN;
			PH_DATA: code = CODE_DATA;
			default: code = CODE_SYNC;
		endcase
		return code;
	endfunction

endpackage

// File: hdl/slfp_regs.sv
// slfp_regs: apb register file holding the sync byte value
// depends on slfp_pkg

module slfp_regs import slfp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	output logic [BYTE_W-1:0]   sync_value
);

	logic [BYTE_W-1:0]    sync_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	// byte offset bits are ignored, word index selects the register
	assign reg_idx = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready && (reg_idx == REG_SYNC_VALUE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= '0;
		end else if (wr_en) begin
			sync_q <= pwdata[BYTE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_SYNC_VALUE) begin
			prdata = DATA_W'(sync_q);
		end
	end

	assign sync_value = sync_q;

endmodule

// File: hdl/slfp_step.sv
// slfp_step: next-state and result logic for one received byte
// depends on slfp_pkg

module slfp_step import slfp_pkg::*; (
	input  state_t              cur,
	input  logic [BYTE_W-1:0]   rx_byte,
	input  logic [BYTE_W-1:0]   sync_value,
	output state_t              nxt,
	output result_t             res
);

	logic              store;
	logic              done;
	logic [CNT_W-1:0]  cnt_inc;

	always_comb begin
		store   = (CMP_W'(cur.count) < CMP_W'(cur.length))
		       && (CMP_W'(cur.count) < CMP_W'(MAX_PAYLOAD));
		cnt_inc = cur.count + CNT_W'(store);
		done    = 1'b0;
		nxt     = cur;

		res.data_valid = 1'b0;
		res.data_index = '0;
		res.data_byte  = '0;

		case (cur.phase)
			PH_SYNC: begin
				if (rx_byte == sync_value) begin
					nxt.count = '0;
					nxt.phase = PH_CMD;
				end
			end
			PH_CMD: begin
				nxt.command = rx_byte;
				nxt.phase   = PH_LEN;
			end
			PH_LEN: begin
				nxt.length = rx_byte;
				nxt.phase  = PH_DATA;
			end
			PH_DATA: begin
				if (store) begin
					res.data_valid = 1'b1;
					res.data_index = IDX_W'(cur.count);
					res.data_byte  = rx_byte;
				end
				nxt.count = cnt_inc;
				// zero length falls through here too and just eats the byte
				if ((CMP_W'(cnt_inc) >= CMP_W'(cur.length))
				    || (CMP_W'(cnt_inc) >= CMP_W'(MAX_PAYLOAD))) begin
					done      = 1'b1;
					nxt.count = '0;
					nxt.phase = PH_SYNC;
				end
			end
			default: begin
				nxt.phase = PH_SYNC;
			end
		endcase

		res.parse_phase   = phase_code(nxt.phase);
		res.frame_command = nxt.command;
		res.frame_length  = nxt.length;
		res.frame_done    = done;
	end

endmodule

// File: hdl/slfp_core.sv
// slfp_core: input register, parser state and result register
// depends on slfp_pkg and slfp_step

module slfp_core import slfp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [BYTE_W-1:0]   sync_value,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [BYTE_W-1:0]   rx_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output result_t             res
);

	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               out_valid_q;
	result_t            res_q;
	state_t             state_q;
	state_t             state_nxt;
	result_t            res_nxt;
	logic               advance;

	slfp_step u_step (
		.cur        (state_q),
		.rx_byte    (byte_s1),
		.sync_value (sync_value),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	// byte moves into the result register when that slot is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '{phase: PH_SYNC, command: '0, length: '0, count: '0};
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

// File: hdl/sync_length_frame_parser_unit.sv
// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+----------------------------------------
// input     | in        | in_valid / in_ready  | rx_byte
// result    | out       | out_valid / out_ready| parse_phase, data_valid, data_index,
//           |           |                      | data_byte, frame_command, frame_length,
//           |           |                      | frame_done
// config    | in        | apb psel/penable     | sync_value at byte address 0
//
// one result per byte; a byte passes through the input register into the result
// register, and a new byte is taken every cycle unless the result side stalls
// the parser state updates as the byte enters the result register
// arst_n clears state, phase goes to sync hunting, sync_value goes to zero
// a stalled result holds the result register; one more byte waits in the input stage
// depends on slfp_pkg, slfp_regs, slfp_core

module sync_length_frame_parser_unit import slfp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [BYTE_W-1:0]   rx_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [PHASE_W-1:0]  parse_phase,
	output logic                data_valid,
	output logic [IDX_W-1:0]    data_index,
	output logic [BYTE_W-1:0]   data_byte,
	output logic [BYTE_W-1:0]   frame_command,
	output logic [BYTE_W-1:0]   frame_length,
	output logic                frame_done
);

	logic [BYTE_W-1:0] sync_value;
	result_t           res;

	slfp_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.sync_value (sync_value)
	);

	slfp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.sync_value (sync_value),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.res        (res)
	);

	assign parse_phase   = res.parse_phase;
	assign data_valid    = res.data_valid;
	assign data_index    = res.data_index;
	assign data_byte     = res.data_byte;
	assign frame_command = res.frame_command;
	assign frame_length  = res.frame_length;
	assign frame_done    = res.frame_done;

endmodule

// File: hdl/slfp_checker.sv
// slfp_checker: port-level checks on the frame parser results, bound to the top level
// depends on slfp_pkg and sync_length_frame_parser_unit

module slfp_checker import slfp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [PHASE_W-1:0]  parse_phase,
	input  logic                data_valid,
	input  logic [IDX_W-1:0]    data_index,
	input  logic [BYTE_W-1:0]   data_byte,
	input  logic                frame_done
);

	// a finished frame always goes back to hunting
	a_done_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> parse_phase == CODE_SYNC)
		else $error("frame_done without return to sync hunting");

	// stored bytes only come from the payload phase
	a_store_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && data_valid |-> parse_phase == CODE_DATA || frame_done)
		else $error("payload byte stored outside payload phase");

	// unused payload fields read as zero
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !data_valid |-> data_index == '0 && data_byte == '0)
		else $error("payload fields nonzero without data_valid");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(data_index))
		else $error("result changed while stalled");

endmodule

bind sync_length_frame_parser_unit slfp_checker u_slfp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.parse_phase (parse_phase),
	.data_valid  (data_valid),
	.data_index  (data_index),
	.data_byte   (data_byte),
	.frame_done  (frame_done)
);
